FILE: rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB/HSV converter package
// Widths, hue constants and the sideband record shared by the pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CHANNEL_BITS = 16;
   localparam int HUE_BITS     = 15;
   localparam int FRAC_BITS    = 12;
   localparam int NUM_BITS     = 19;
   localparam int DVD_BITS     = 44;
   localparam int DVS_BITS     = 28;
   localparam int QUO_BITS     = 16;

   localparam logic [HUE_BITS-1:0] HUE_SECTOR = 15'd3840;
   localparam logic [HUE_BITS-1:0] HUE_FULL   = 15'd23040;
   localparam logic [CHANNEL_BITS-1:0] CH_FULL = {CHANNEL_BITS{1'b1}};
   localparam logic [DVS_BITS-1:0] RGB_DEN = 28'(65535 * 3840);

   localparam logic CMD_TO_HSV = 1'b0;
   localparam logic CMD_TO_RGB = 1'b1;

   localparam logic [2:0] SEC_RED   = 3'd0;
   localparam logic [2:0] SEC_GREEN = 3'd2;
   localparam logic [2:0] SEC_BLUE  = 3'd4;

   typedef struct packed {
      logic                    cmd;
      logic [CHANNEL_BITS-1:0] val;
      logic                    gray;
      logic                    szero;
      logic [2:0]              sector;
   } band_type;

endpackage

FILE: rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// RGB/HSV converter front end
// Three register stages: channel analysis, first products, divider operands.
// ----------------------------------------------------------------------------
module rhc_front import rhc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic                    cmd,
   input  logic [CHANNEL_BITS-1:0] red,
   input  logic [CHANNEL_BITS-1:0] green,
   input  logic [CHANNEL_BITS-1:0] blue,
   input  logic [HUE_BITS-1:0]     hue_in,
   input  logic [CHANNEL_BITS-1:0] sat_in,
   input  logic [CHANNEL_BITS-1:0] val_in,
   output logic                    out_valid,
   output band_type                out_band,
   output logic [DVD_BITS-1:0]     dvd_a,
   output logic [DVS_BITS-1:0]     dvs_a,
   output logic [DVD_BITS-1:0]     dvd_b,
   output logic [DVS_BITS-1:0]     dvs_b
);

   logic [CHANNEL_BITS-1:0] mx, mn, delta;
   logic [NUM_BITS:0]       num_wide;
   logic [HUE_BITS-1:0]     h, base;
   logic [2:0]              hsec;
   band_type                band1_in;

   logic                    v1_ff, v2_ff, v3_ff;
   band_type                band1_ff, band2_ff, band3_ff;
   logic [NUM_BITS-1:0]     num1_ff;
   logic [CHANNEL_BITS-1:0] delta1_ff, delta2_ff, sat1_ff;
   logic [FRAC_BITS-1:0]    frac1_ff;
   logic [30:0]             hdvd2_ff;
   logic [31:0]             sdvd2_ff, xdvd2_ff;
   logic [27:0]             sf2_ff;
   logic [DVD_BITS-1:0]     dvd_a_ff, dvd_b_ff;
   logic [DVS_BITS-1:0]     dvs_a_ff, dvs_b_ff;

   always_comb begin
      mx = (red > green) ? red : green;
      mx = (mx > blue) ? mx : blue;
      mn = (red < green) ? red : green;
      mn = (mn < blue) ? mn : blue;
      delta = mx - mn;
      if (red == mx) begin
         num_wide = (green >= blue) ? 20'(green) - 20'(blue)
                                    : 20'(delta) * 20'd6 + 20'(green) - 20'(blue);
         hsec = SEC_RED;
      end else if (green == mx) begin
         num_wide = 20'(delta) * 20'd2 + 20'(blue) - 20'(red);
         hsec = SEC_GREEN;
      end else begin
         num_wide = 20'(delta) * 20'd4 + 20'(red) - 20'(green);
         hsec = SEC_BLUE;
      end
      h = (hue_in >= HUE_FULL) ? '0 : hue_in;
      band1_in.cmd = cmd;
      band1_in.gray = (mx == '0) || (delta == '0);
      band1_in.szero = (sat_in == '0);
      if (cmd == CMD_TO_RGB) begin
         band1_in.val = val_in;
         if (h < 15'd3840) begin
            band1_in.sector = 3'd0;
            base = 15'd0;
         end else if (h < 15'd7680) begin
            band1_in.sector = 3'd1;
            base = 15'd3840;
         end else if (h < 15'd11520) begin
            band1_in.sector = 3'd2;
            base = 15'd7680;
         end else if (h < 15'd15360) begin
            band1_in.sector = 3'd3;
            base = 15'd11520;
         end else if (h < 15'd19200) begin
            band1_in.sector = 3'd4;
            base = 15'd15360;
         end else begin
            band1_in.sector = 3'd5;
            base = 15'd19200;
         end
      end else begin
         band1_in.val = mx;
         band1_in.sector = hsec;
         base = h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         band1_ff  <= band1_in;
         num1_ff   <= num_wide[NUM_BITS-1:0];
         delta1_ff <= delta;
         sat1_ff   <= sat_in;
         frac1_ff  <= FRAC_BITS'(h - base);

         band2_ff  <= band1_ff;
         delta2_ff <= delta1_ff;
         hdvd2_ff  <= 31'(num1_ff) * 31'(HUE_SECTOR);
         sdvd2_ff  <= {delta1_ff, 16'd0} - 32'(delta1_ff);
         sf2_ff    <= 28'(sat1_ff) * 28'(frac1_ff);
         xdvd2_ff  <= 32'(band1_ff.val) * 32'(CH_FULL - sat1_ff);

         band3_ff  <= band2_ff;
         if (band2_ff.cmd == CMD_TO_RGB) begin
            dvd_a_ff <= 44'(xdvd2_ff);
            dvs_a_ff <= 28'(CH_FULL);
            dvd_b_ff <= 44'(band2_ff.val) * 44'(RGB_DEN - sf2_ff);
            dvs_b_ff <= RGB_DEN;
         end else begin
            dvd_a_ff <= 44'(sdvd2_ff);
            dvs_a_ff <= band2_ff.gray ? 28'd1 : 28'(band2_ff.val);
            dvd_b_ff <= 44'(hdvd2_ff);
            dvs_b_ff <= band2_ff.gray ? 28'd1 : 28'(delta2_ff);
         end
      end
   end

   assign out_valid = v3_ff;
   assign out_band  = band3_ff;
   assign dvd_a     = dvd_a_ff;
   assign dvs_a     = dvs_a_ff;
   assign dvd_b     = dvd_b_ff;
   assign dvs_b     = dvs_b_ff;

endmodule

FILE: rtl/rhc_div.sv
// ----------------------------------------------------------------------------
// RGB/HSV converter divider
// Restoring division, one quotient bit per register stage, with the final
// remainder passed out beside the quotient.
// ----------------------------------------------------------------------------
module rhc_div import rhc_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic [QUO_BITS-1:0] quotient,
   output logic [DVS_BITS-1:0] remainder
);

   logic [DVD_BITS-1:0] rem_ff [QUO_BITS];
   logic [DVS_BITS-1:0] dvs_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [DVD_BITS-1:0] rem_prev, trial, rem_in;
      logic [DVS_BITS-1:0] dvs_prev;
      logic [QUO_BITS-1:0] quo_prev, quo_in;

      if (k == 0) begin : g_head
         assign rem_prev = dividend;
         assign dvs_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_tail
         assign rem_prev = rem_ff[k-1];
         assign dvs_prev = dvs_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      always_comb begin
         trial = DVD_BITS'(dvs_prev) << (QUO_BITS - 1 - k);
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            quo_in = quo_prev | (QUO_BITS'(1) << (QUO_BITS - 1 - k));
         end else begin
            rem_in = rem_prev;
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            dvs_ff[k] <= dvs_prev;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quotient  = quo_ff[QUO_BITS-1];
   assign remainder = rem_ff[QUO_BITS-1][DVS_BITS-1:0];

endmodule

FILE: rtl/rgb_hsv_color_convert_core.sv
// ----------------------------------------------------------------------------
// RGB/HSV color converter
// An accepted beat passes the front end, the dividers and the result register.
// Throughput is one beat per cycle while no result beat waits; the two 16-stage dividers set the depth.
// The whole pipeline holds while a result beat waits, so nothing is lost.
// Synchronous reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_hsv_color_convert_core import rhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // red[15:0] green[31:16] blue[47:32] hue_in[62:48] sat_in[78:63] val_in[94:79]
   input  logic [95:0] req_tdata,
   // cmd[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red_out[15:0] green_out[31:16] blue_out[47:32] hue_out[62:48]
   // sat_out[78:63] val_out[94:79]
   output logic [95:0] rsp_tdata,
   // hue_undefined[0]
   output logic        rsp_tuser
);

   logic                en;
   logic                f_valid;
   band_type            f_band;
   logic [DVD_BITS-1:0] dvd_a, dvd_b;
   logic [DVS_BITS-1:0] dvs_a, dvs_b;
   logic [QUO_BITS-1:0] q_a, q_b;
   logic [DVS_BITS-1:0] r_a, r_b;

   logic                valid_ff [QUO_BITS];
   band_type            band_ff  [QUO_BITS];
   logic                rsp_valid_ff;
   logic [95:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;

   assign en = !rsp_valid_ff || rsp_tready;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .cmd       (req_tuser),
      .red       (req_tdata[15:0]),
      .green     (req_tdata[31:16]),
      .blue      (req_tdata[47:32]),
      .hue_in    (req_tdata[62:48]),
      .sat_in    (req_tdata[78:63]),
      .val_in    (req_tdata[94:79]),
      .out_valid (f_valid),
      .out_band  (f_band),
      .dvd_a     (dvd_a),
      .dvs_a     (dvs_a),
      .dvd_b     (dvd_b),
      .dvs_b     (dvs_b)
   );

   rhc_div u_div_a (.clock(clock), .en(en), .dividend(dvd_a), .divisor(dvs_a),
                    .quotient(q_a), .remainder(r_a));
   rhc_div u_div_b (.clock(clock), .en(en), .dividend(dvd_b), .divisor(dvs_b),
                    .quotient(q_b), .remainder(r_b));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_BITS; k++) valid_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= f_valid;
         for (int k = 1; k < QUO_BITS; k++) valid_ff[k] <= valid_ff[k-1];
         rsp_valid_ff <= valid_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         band_ff[0] <= f_band;
         for (int k = 1; k < QUO_BITS; k++) band_ff[k] <= band_ff[k-1];
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // The third RGB term follows from the other two: z = v + x - y, less one
   // when the remainder of y exceeds the scaled remainder of x.
   always_comb begin
      band_type                b;
      logic [CHANNEL_BITS-1:0] rr, gg, bb, v, z;
      logic [DVS_BITS-1:0]     rk;
      logic [CHANNEL_BITS+1:0] zsum;
      b = band_ff[QUO_BITS-1];
      v = b.val;
      rk = r_a * DVS_BITS'(HUE_SECTOR);
      zsum = {2'b00, v} + {2'b00, q_a} - {2'b00, q_b};
      if (r_b > rk) zsum = zsum - {{(CHANNEL_BITS+1){1'b0}}, 1'b1};
      z = zsum[CHANNEL_BITS-1:0];
      rsp_data_in = '0;
      rsp_user_in = 1'b0;
      rr = v;
      gg = v;
      bb = v;
      if (b.cmd == CMD_TO_HSV) begin
         rsp_data_in[94:79] = v;
         rsp_user_in = b.gray;
         if (!b.gray) begin
            rsp_data_in[62:48] = q_b[HUE_BITS-1:0];
            rsp_data_in[78:63] = q_a;
         end
      end else begin
         if (!b.szero) begin
            case (b.sector)
               3'd0: begin rr = v;   gg = z;   bb = q_a; end
               3'd1: begin rr = q_b; gg = v;   bb = q_a; end
               3'd2: begin rr = q_a; gg = v;   bb = z;   end
               3'd3: begin rr = q_a; gg = q_b; bb = v;   end
               3'd4: begin rr = z;   gg = q_a; bb = v;   end
               default: begin rr = v; gg = q_a; bb = q_b; end
            endcase
         end
         rsp_data_in[15:0]  = rr;
         rsp_data_in[31:16] = gg;
         rsp_data_in[47:32] = bb;
         rsp_data_in[94:79] = v;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/rhc_checker.sv
// ----------------------------------------------------------------------------
// RGB/HSV converter port checker
// Checks reset, stall and undefined-hue behavior seen on the ports.
// ----------------------------------------------------------------------------
module rhc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result beat valid right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("Stalled result beat changed.");

   a_undef_zero_hs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[78:48] == '0)
      else $error("Undefined hue with nonzero hue or saturation.");

   a_undef_zero_rgb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:0] == '0)
      else $error("Undefined hue with nonzero RGB fields.");

endmodule

bind rgb_hsv_color_convert_core rhc_checker u_rhc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
